// ===== sv/jseu_pkg.sv =====
`default_nettype none

package jseu_pkg;

    localparam int BYTE_W  = 8;
    localparam int BODY_N  = 6;
    localparam int REP_LEN = 6;

    typedef logic [BYTE_W-1:0] t_byte;

    // Characters used in the escaped text.
    localparam t_byte CH_QUOTE  = 8'h22;
    localparam t_byte CH_BSLASH = 8'h5c;
    localparam t_byte CH_LOW_U  = 8'h75;
    localparam t_byte CH_ZERO   = 8'h30;
    localparam t_byte CH_SPACE  = 8'h20;
    localparam t_byte CH_DEL_HI = 8'h80;

    // UTF-8 lead and second-byte bounds.
    localparam t_byte UTF_CONT_MASK = 8'hc0;
    localparam t_byte UTF_CONT_TAG  = 8'h80;
    localparam t_byte UTF_LEAD_MIN  = 8'hc2;
    localparam t_byte UTF_LEAD2_MAX = 8'hdf;
    localparam t_byte UTF_LEAD3_MAX = 8'hef;
    localparam t_byte UTF_LEAD_MAX  = 8'hf4;
    localparam t_byte UTF_E0        = 8'he0;
    localparam t_byte UTF_E0_MIN    = 8'ha0;
    localparam t_byte UTF_ED        = 8'hed;
    localparam t_byte UTF_ED_MAX    = 8'h9f;
    localparam t_byte UTF_F0        = 8'hf0;
    localparam t_byte UTF_F0_MIN    = 8'h90;
    localparam t_byte UTF_F4        = 8'hf4;
    localparam t_byte UTF_F4_MAX    = 8'h8f;

    // Emission plan for one transfer, walked byte by byte by the emitter.
    typedef struct packed {
        logic                          open_q;
        logic [1:0]                    rep_a;
        logic [2:0]                    body_cnt;
        logic [BODY_N-1:0][BYTE_W-1:0] body;
        logic [1:0]                    rep_b;
        logic                          close_q;
    } t_plan;

    function automatic t_byte hex_char(input logic [3:0] nib);
        t_byte c;
        if (nib < 4'd10) begin
            c = CH_ZERO + {4'd0, nib};
        end else begin
            c = 8'h61 + {4'd0, nib - 4'd10};
        end
        return c;
    endfunction

    // Character of the six-character sequence \ufffd at a position.
    function automatic t_byte rep_char(input logic [2:0] idx);
        t_byte c;
        unique case (idx)
            3'd0:    c = CH_BSLASH;
            3'd1:    c = CH_LOW_U;
            3'd5:    c = 8'h64;
            default: c = 8'h66;
        endcase
        return c;
    endfunction

    // Second character of a two-character escape, zero if none applies.
    function automatic t_byte esc_second(input t_byte b);
        t_byte c;
        unique case (b)
            8'h22:   c = 8'h22;
            8'h5c:   c = 8'h5c;
            8'h08:   c = 8'h62;
            8'h0c:   c = 8'h66;
            8'h0a:   c = 8'h6e;
            8'h0d:   c = 8'h72;
            8'h09:   c = 8'h74;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/jseu_if.sv =====
`default_nettype none

interface jseu_in_if;
    logic                 valid;
    logic                 ready;
    jseu_pkg::t_byte      data_byte;
    logic                 has_byte;
    logic                 string_end;

    modport source (output valid, output data_byte, output has_byte, output string_end,
                    input ready);
    modport sink   (input valid, input data_byte, input has_byte, input string_end,
                    output ready);
endinterface

interface jseu_out_if;
    logic                 valid;
    logic                 ready;
    jseu_pkg::t_byte      out_byte;
    logic                 run_last;
    logic                 string_done;

    modport source (output valid, output out_byte, output run_last, output string_done,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input string_done,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/jseu_decode.sv =====
`default_nettype none

module jseu_decode (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_take,
    input  wire jseu_pkg::t_byte i_data_byte,
    input  wire logic            i_has_byte,
    input  wire logic            i_string_end,
    output jseu_pkg::t_plan      o_plan
);
    import jseu_pkg::*;

    logic             r_in_string, n_in_string;
    logic [2:0][7:0]  r_pend, n_pend;
    logic [1:0]       r_cnt, n_cnt;
    logic [2:0]       r_seqlen, n_seqlen;

    logic             pend_ok;
    logic             fits;
    logic             bad_lead;
    t_byte            two;
    t_plan            plan;

    always_comb begin
        plan        = '0;
        n_in_string = r_in_string;
        n_pend      = r_pend;
        n_cnt       = r_cnt;
        n_seqlen    = r_seqlen;
        bad_lead    = 1'b0;
        two         = esc_second(i_data_byte);

        pend_ok = (r_cnt != 2'd0) && (r_seqlen > {1'b0, r_cnt}) && (r_seqlen <= 3'd4);
        fits    = ((i_data_byte & UTF_CONT_MASK) == UTF_CONT_TAG);
        if (r_cnt == 2'd1) begin
            if (r_pend[0] == UTF_E0) begin
                fits = fits && (i_data_byte >= UTF_E0_MIN);
            end else if (r_pend[0] == UTF_ED) begin
                fits = fits && (i_data_byte <= UTF_ED_MAX);
            end else if (r_pend[0] == UTF_F0) begin
                fits = fits && (i_data_byte >= UTF_F0_MIN);
            end else if (r_pend[0] == UTF_F4) begin
                fits = fits && (i_data_byte <= UTF_F4_MAX);
            end
        end

        plan.open_q = (i_has_byte || i_string_end) && !r_in_string;

        if (i_has_byte) begin
            if (pend_ok && fits) begin
                if (({1'b0, r_cnt} + 3'd1) == r_seqlen) begin
                    // Sequence complete: pass the held bytes and this one unchanged.
                    plan.body[0]              = r_pend[0];
                    plan.body[1]              = r_pend[1];
                    plan.body[2]              = r_pend[2];
                    plan.body[{1'b0, r_cnt}]  = i_data_byte;
                    plan.body_cnt             = {1'b0, r_cnt} + 3'd1;
                    n_cnt                     = 2'd0;
                    n_seqlen                  = 3'd0;
                end else if (r_cnt != 2'd3) begin
                    n_pend[r_cnt] = i_data_byte;
                    n_cnt         = r_cnt + 2'd1;
                end
            end else begin
                // Flush whatever is held, then treat the byte as a new lead.
                plan.rep_a = r_cnt;
                n_cnt      = 2'd0;
                n_seqlen   = 3'd0;
                priority if (two != 8'h00) begin
                    plan.body[0]  = CH_BSLASH;
                    plan.body[1]  = two;
                    plan.body_cnt = 3'd2;
                end else if (i_data_byte < CH_SPACE) begin
                    plan.body[0]  = CH_BSLASH;
                    plan.body[1]  = CH_LOW_U;
                    plan.body[2]  = CH_ZERO;
                    plan.body[3]  = CH_ZERO;
                    plan.body[4]  = hex_char(i_data_byte[7:4]);
                    plan.body[5]  = hex_char(i_data_byte[3:0]);
                    plan.body_cnt = 3'd6;
                end else if (i_data_byte < CH_DEL_HI) begin
                    plan.body[0]  = i_data_byte;
                    plan.body_cnt = 3'd1;
                end else if (i_data_byte >= UTF_LEAD_MIN && i_data_byte <= UTF_LEAD_MAX) begin
                    n_pend[0] = i_data_byte;
                    n_cnt     = 2'd1;
                    if (i_data_byte <= UTF_LEAD2_MAX) begin
                        n_seqlen = 3'd2;
                    end else if (i_data_byte <= UTF_LEAD3_MAX) begin
                        n_seqlen = 3'd3;
                    end else begin
                        n_seqlen = 3'd4;
                    end
                end else begin
                    bad_lead = 1'b1;
                end
            end
        end

        plan.rep_b = {1'b0, bad_lead};
        if (i_string_end) begin
            plan.rep_b    = plan.rep_b + n_cnt;
            plan.close_q  = 1'b1;
            n_cnt         = 2'd0;
            n_seqlen      = 3'd0;
            n_in_string   = 1'b0;
        end else if (i_has_byte) begin
            n_in_string = 1'b1;
        end

        o_plan = plan;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_string <= 1'b0;
            r_cnt       <= 2'd0;
            r_seqlen    <= 3'd0;
        end else if (i_take) begin
            r_in_string <= n_in_string;
            r_cnt       <= n_cnt;
            r_seqlen    <= n_seqlen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_pend <= n_pend;
        end
    end

    a_len_above_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd0 |-> r_seqlen > {1'b0, r_cnt})
        else $error("held count not below expected sequence length");
    a_len_zero_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd0 |-> r_seqlen == 3'd0)
        else $error("sequence length left over with nothing held");
    a_hold_inside_string: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd0 |-> r_in_string)
        else $error("bytes held outside a string");

endmodule

`default_nettype wire

// ===== sv/jseu_emit.sv =====
`default_nettype none

module jseu_emit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_load,
    input  wire jseu_pkg::t_plan i_plan,
    output logic                o_can_load,
    jseu_out_if.source          o_out
);
    import jseu_pkg::*;

    logic                          r_busy;
    logic                          r_open, n_open;
    logic [1:0]                    r_rep_a, n_rep_a;
    logic [2:0]                    r_body_cnt, n_body_cnt;
    logic [BODY_N-1:0][BYTE_W-1:0] r_body, n_body;
    logic [1:0]                    r_rep_b, n_rep_b;
    logic                          r_close, n_close;
    logic [2:0]                    r_rep_idx, n_rep_idx;

    logic                          r_ovalid;
    t_byte                         r_obyte;
    logic                          r_olast;
    logic                          r_odone;

    t_byte                         cur_byte;
    logic                          cur_done;
    logic                          adv;
    logic                          last;
    logic                          plan_nonempty;

    assign plan_nonempty = i_plan.open_q || (i_plan.rep_a != 2'd0) ||
                           (i_plan.body_cnt != 3'd0) || (i_plan.rep_b != 2'd0) ||
                           i_plan.close_q;

    assign adv = r_busy && (!r_ovalid || o_out.ready);

    always_comb begin
        n_open     = r_open;
        n_rep_a    = r_rep_a;
        n_body_cnt = r_body_cnt;
        n_body     = r_body;
        n_rep_b    = r_rep_b;
        n_close    = r_close;
        n_rep_idx  = r_rep_idx;
        cur_byte   = CH_QUOTE;
        cur_done   = 1'b0;

        priority if (r_open) begin
            n_open = 1'b0;
        end else if (r_rep_a != 2'd0) begin
            cur_byte = rep_char(r_rep_idx);
            if (r_rep_idx == 3'(REP_LEN - 1)) begin
                n_rep_idx = 3'd0;
                n_rep_a   = r_rep_a - 2'd1;
            end else begin
                n_rep_idx = r_rep_idx + 3'd1;
            end
        end else if (r_body_cnt != 3'd0) begin
            cur_byte   = r_body[0];
            n_body     = r_body >> BYTE_W;
            n_body_cnt = r_body_cnt - 3'd1;
        end else if (r_rep_b != 2'd0) begin
            cur_byte = rep_char(r_rep_idx);
            if (r_rep_idx == 3'(REP_LEN - 1)) begin
                n_rep_idx = 3'd0;
                n_rep_b   = r_rep_b - 2'd1;
            end else begin
                n_rep_idx = r_rep_idx + 3'd1;
            end
        end else begin
            cur_done = 1'b1;
            n_close  = 1'b0;
        end

        last = !n_open && (n_rep_a == 2'd0) && (n_body_cnt == 3'd0) &&
               (n_rep_b == 2'd0) && !n_close;
    end

    assign o_can_load = !r_busy || (adv && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_load) begin
            r_busy <= plan_nonempty;
        end else if (adv) begin
            r_busy <= !last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_open     <= i_plan.open_q;
            r_rep_a    <= i_plan.rep_a;
            r_body_cnt <= i_plan.body_cnt;
            r_body     <= i_plan.body;
            r_rep_b    <= i_plan.rep_b;
            r_close    <= i_plan.close_q;
            r_rep_idx  <= 3'd0;
        end else if (adv) begin
            r_open     <= n_open;
            r_rep_a    <= n_rep_a;
            r_body_cnt <= n_body_cnt;
            r_body     <= n_body;
            r_rep_b    <= n_rep_b;
            r_close    <= n_close;
            r_rep_idx  <= n_rep_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (adv) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_obyte <= cur_byte;
            r_olast <= last;
            r_odone <= cur_done;
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.out_byte    = r_obyte;
    assign o_out.run_last    = r_olast;
    assign o_out.string_done = r_odone;

    a_done_is_last_quote: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_odone |-> r_olast && (r_obyte == CH_QUOTE))
        else $error("closing quote not the last byte of its run");
    a_busy_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_open || (r_rep_a != 2'd0) || (r_body_cnt != 3'd0) ||
                    (r_rep_b != 2'd0) || r_close))
        else $error("emitter busy with an empty plan");
    a_load_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load && plan_nonempty |=> r_busy)
        else $error("loaded plan not taken up");

endmodule

`default_nettype wire

// ===== sv/json_string_escaper_utf8.sv =====
`default_nettype none

// Channel   Direction  Payload                                 Transfer when
// i_in      in         data_byte[7:0], has_byte, string_end    valid && ready
// o_out     out        out_byte[7:0], run_last, string_done    valid && ready
//
// A transfer that yields k output bytes holds the input; ready rises again in the
// cycle the last of them enters the output register, so plain printable bytes
// stream at one per cycle unless the output stalls. An idle transfer has no output.
// The longest run is 25 bytes: three held bytes flushed as replacements, six bytes
// for the new byte's escape or replacement, and the closing quote.
// Reset is synchronous and active low; it clears the UTF-8 hold state and empties
// the output register. A stalled output holds its byte while one more transfer
// may be taken into the emitter.

module json_string_escaper_utf8 (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    jseu_in_if.sink    i_in,
    jseu_out_if.source o_out
);
    import jseu_pkg::*;

    logic  can_load;
    logic  take;
    t_plan plan;

    // The decoder sees the offered item and the held UTF-8 state, and turns it into
    // a compact plan: opening quote, replacements for a broken sequence, the body
    // bytes (a pass-through sequence or an escape), trailing replacements and the
    // closing quote. Its state moves on only when the transfer completes.
    assign i_in.ready = can_load;
    assign take       = i_in.valid && can_load;

    jseu_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_data_byte  (i_in.data_byte),
        .i_has_byte   (i_in.has_byte),
        .i_string_end (i_in.string_end),
        .o_plan       (plan)
    );

    // The emitter holds one plan and walks it into the output register one byte per
    // cycle while the output moves, marking each run's last byte and the closing quote.
    jseu_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (take),
        .i_plan     (plan),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

// ===== tb/json_string_escaper_utf8_tb.sv =====
`timescale 1ns / 100ps

module json_string_escaper_utf8_tb;
    import jseu_pkg::*;

    // Run shape. The limit covers the worst case with a wide margin: every transfer
    // yielding 25 bytes, each byte waiting out a long receiver stall, plus the long
    // hold-off below.
    localparam int RANDOM_ITEMS  = 100;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 60;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_RUN       = 25;
    localparam int REPORT_LIMIT  = 10;
    localparam int RESET_CYCLES  = 6;

    // One escaped output byte together with its two flags.
    typedef struct packed {
        t_byte ch;
        logic  last;
        logic  done;
    } t_esc_char;

    // One row of the directed table. Where typed_on is set, the escaped text is
    // written out by hand; run_last goes on its last byte, and string_done too if
    // the row ends the string. Other rows are checked against the predictor.
    typedef struct {
        t_byte data;
        bit    has;
        bit    fin;
        bit    typed_on;
        string typed;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 26;

    t_stim_row directed [DIRECTED_ROWS] = '{
        '{8'h00, 1'b0, 1'b0, 1'b1, ""},               // idle transfer, no output
        '{8'hff, 1'b0, 1'b1, 1'b1, "\"\""},           // empty string
        '{8'h00, 1'b1, 1'b0, 1'b1, "\"\\u0000"},      // zero byte opens a string
        '{8'h1f, 1'b1, 1'b0, 1'b1, "\\u001f"},
        '{8'h22, 1'b1, 1'b0, 1'b1, "\\\""},
        '{8'h5c, 1'b1, 1'b0, 1'b1, "\\\\"},
        '{8'h08, 1'b1, 1'b0, 1'b1, "\\b"},
        '{8'h0c, 1'b1, 1'b0, 1'b1, "\\f"},
        '{8'h0a, 1'b1, 1'b0, 1'b1, "\\n"},
        '{8'h0d, 1'b1, 1'b0, 1'b1, "\\r"},
        '{8'h09, 1'b1, 1'b0, 1'b1, "\\t"},
        '{8'h7f, 1'b1, 1'b0, 1'b0, ""},
        '{8'h80, 1'b1, 1'b0, 1'b1, "\\ufffd"},        // stray continuation as lead
        '{8'hff, 1'b1, 1'b1, 1'b1, "\\ufffd\""},      // bad lead, then close
        '{8'hc2, 1'b1, 1'b0, 1'b1, "\""},             // open; 0xc2 is held
        '{8'h9f, 1'b1, 1'b0, 1'b0, ""},               // completes c2 9f
        '{8'he0, 1'b1, 1'b0, 1'b0, ""},
        '{8'h9f, 1'b1, 1'b0, 1'b0, ""},               // below the e0 second-byte floor
        '{8'hf4, 1'b1, 1'b0, 1'b0, ""},
        '{8'h90, 1'b1, 1'b0, 1'b0, ""},               // above the f4 second-byte ceiling
        '{8'hf0, 1'b1, 1'b0, 1'b0, ""},
        '{8'h90, 1'b1, 1'b0, 1'b0, ""},
        '{8'h80, 1'b1, 1'b0, 1'b0, ""},
        '{8'hff, 1'b1, 1'b1, 1'b0, ""},               // three held, bad lead, close: 25 bytes
        '{8'he2, 1'b1, 1'b0, 1'b0, ""},
        '{8'h82, 1'b1, 1'b1, 1'b0, ""}                // string ends inside a sequence
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    jseu_in_if  in_if ();
    jseu_out_if out_if ();

    json_string_escaper_utf8 uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #6 i_clk = ~i_clk;

    // Escaped bytes still owed by the block, oldest first, and the bytes that the
    // predictor produced for the transfer it handled last.
    t_esc_char expected_chars [$];
    t_esc_char item_chars [$];

    // Predictor state: inside a string or not, and the held part of a UTF-8 sequence.
    bit    model_open;
    t_byte model_held [3];
    int    model_held_n;
    int    model_seq_len;

    int err_count     = 0;
    int chars_checked = 0;
    int strings_seen  = 0;
    int items_sent    = 0;
    int cycle_count   = 0;

    // Traffic shaping shared by both sides. quiet turns off the random gaps; each step of
    // hold_asks asks the receiver for one long hold-off, which it times itself.
    bit quiet     = 1'b0;
    int hold_asks = 0;
    int hold_served = 0;
    int hold_left   = 0;
    int stall_left  = 0;

    function automatic void note_error(input string msg);
        err_count++;
        if (err_count <= REPORT_LIMIT) begin
            $display("%s", msg);
        end
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic void emit(input t_byte c, input bit done);
        if (item_chars.size() < MAX_RUN) begin
            item_chars.push_back('{ch: c, last: 1'b0, done: done});
        end
    endfunction

    // The replacement character written as the six bytes \ufffd.
    function automatic void emit_fffd();
        emit(CH_BSLASH, 1'b0);
        emit(CH_LOW_U, 1'b0);
        emit("f", 1'b0);
        emit("f", 1'b0);
        emit("f", 1'b0);
        emit("d", 1'b0);
    endfunction

    // Every held byte of an unfinished sequence turns into one replacement.
    function automatic void drop_held();
        int i;
        for (i = 0; i < model_held_n; i++) begin
            emit_fffd();
        end
        model_held_n  = 0;
        model_seq_len = 0;
        model_held    = '{default: 8'h00};
    endfunction

    // A continuation byte, with the tighter second-byte ranges after e0, ed, f0, f4.
    function automatic bit continues_seq(input t_byte b);
        if ((b & UTF_CONT_MASK) != UTF_CONT_TAG) begin
            return 1'b0;
        end
        if (model_held_n == 1) begin
            case (model_held[0])
                UTF_E0:  return b >= UTF_E0_MIN;
                UTF_ED:  return b <= UTF_ED_MAX;
                UTF_F0:  return b >= UTF_F0_MIN;
                UTF_F4:  return b <= UTF_F4_MAX;
                default: return 1'b1;
            endcase
        end
        return 1'b1;
    endfunction

    // A byte seen with nothing held: escape it, pass it, hold it as a lead, or
    // replace it when it cannot start a sequence.
    function automatic void open_char(input t_byte b);
        t_byte      second;
        string      hex_set;
        hex_set = "0123456789abcdef";
        case (b)
            CH_QUOTE:  second = CH_QUOTE;
            CH_BSLASH: second = CH_BSLASH;
            8'h08:     second = "b";
            8'h0c:     second = "f";
            8'h0a:     second = "n";
            8'h0d:     second = "r";
            8'h09:     second = "t";
            default:   second = 8'h00;
        endcase
        if (second != 8'h00) begin
            emit(CH_BSLASH, 1'b0);
            emit(second, 1'b0);
        end else if (b < CH_SPACE) begin
            emit(CH_BSLASH, 1'b0);
            emit(CH_LOW_U, 1'b0);
            emit(CH_ZERO, 1'b0);
            emit(CH_ZERO, 1'b0);
            emit(hex_set[b[7:4]], 1'b0);
            emit(hex_set[b[3:0]], 1'b0);
        end else if (b < CH_DEL_HI) begin
            emit(b, 1'b0);
        end else if (b >= UTF_LEAD_MIN && b <= UTF_LEAD_MAX) begin
            model_held[0] = b;
            model_held_n  = 1;
            model_seq_len = (b <= UTF_LEAD2_MAX) ? 2 : (b <= UTF_LEAD3_MAX) ? 3 : 4;
        end else begin
            emit_fffd();
        end
    endfunction

    function automatic void take_char(input t_byte b);
        int i;
        if (model_held_n > 0) begin
            if (continues_seq(b)) begin
                if (model_held_n + 1 == model_seq_len) begin
                    for (i = 0; i < model_held_n; i++) begin
                        emit(model_held[i], 1'b0);
                    end
                    emit(b, 1'b0);
                    model_held_n  = 0;
                    model_seq_len = 0;
                    model_held    = '{default: 8'h00};
                end else begin
                    model_held[model_held_n] = b;
                    model_held_n++;
                end
                return;
            end
            // The byte breaks the sequence: flush, then look at it as a new lead.
            drop_held();
        end
        open_char(b);
    endfunction

    // Escaped output for one accepted transfer, left in item_chars.
    function automatic void escape_item(input t_byte b, input bit has, input bit fin);
        item_chars.delete();
        if (!has && !fin) begin
            return;
        end
        if (!model_open) begin
            emit(CH_QUOTE, 1'b0);
            model_open = 1'b1;
        end
        if (has) begin
            take_char(b);
        end
        if (fin) begin
            drop_held();
            emit(CH_QUOTE, 1'b1);
            model_open = 1'b0;
        end
        if (item_chars.size() > 0) begin
            item_chars[item_chars.size() - 1].last = 1'b1;
        end
    endfunction

    // Offer one transfer after a random gap and wait until the block takes it. The
    // valid line is raised or lowered at most once per edge; a transfer that follows
    // with no gap keeps valid high.
    task automatic offer(input t_byte b, input bit has, input bit fin,
                         input bit typed_on, input string typed);
        int gap;
        int i;
        int n;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.data_byte  <= b;
        in_if.has_byte   <= has;
        in_if.string_end <= fin;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        escape_item(b, has, fin);
        if (typed_on) begin
            n = typed.len();
            for (i = 0; i < n; i++) begin
                expected_chars.push_back('{ch: typed[i], last: (i == n - 1),
                                           done: (fin && i == n - 1)});
            end
        end else begin
            foreach (item_chars[i]) begin
                expected_chars.push_back(item_chars[i]);
            end
        end
        if (has || fin) begin
            items_sent++;
        end
    endtask

    task automatic offer_char(input t_byte b);
        offer(b, 1'b1, ($urandom_range(0, 11) == 0), 1'b0, "");
    endtask

    // One random piece of a string. Well-formed UTF-8 sequences and ordinary text
    // make up most of it so the sequence checker gets past its first byte; the rest
    // is escapes, broken or truncated sequences, bad leads, string ends and idle transfers.
    task automatic send_token();
        int    kind;
        int    len;
        int    k;
        t_byte lead;
        t_byte second;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            offer_char(t_byte'($urandom_range(8'h20, 8'h7f)));
        end else if (kind < 40) begin
            k = $urandom_range(0, 3);
            offer_char(k == 0 ? CH_QUOTE : k == 1 ? CH_BSLASH : t_byte'($urandom_range(0, 31)));
        end else if (kind < 65) begin
            len = $urandom_range(2, 4);
            if (len == 2) begin
                lead = t_byte'($urandom_range(UTF_LEAD_MIN, UTF_LEAD2_MAX));
            end else if (len == 3) begin
                lead = t_byte'($urandom_range(UTF_E0, UTF_LEAD3_MAX));
            end else begin
                lead = t_byte'($urandom_range(UTF_F0, UTF_LEAD_MAX));
            end
            case (lead)
                UTF_E0:  second = t_byte'($urandom_range(UTF_E0_MIN, 8'hbf));
                UTF_ED:  second = t_byte'($urandom_range(8'h80, UTF_ED_MAX));
                UTF_F0:  second = t_byte'($urandom_range(UTF_F0_MIN, 8'hbf));
                UTF_F4:  second = t_byte'($urandom_range(8'h80, UTF_F4_MAX));
                default: second = t_byte'($urandom_range(8'h80, 8'hbf));
            endcase
            offer_char(lead);
            offer_char(second);
            for (k = 2; k < len; k++) begin
                offer_char(t_byte'($urandom_range(8'h80, 8'hbf)));
            end
        end else if (kind < 75) begin
            offer_char(t_byte'($urandom_range(UTF_LEAD_MIN, UTF_LEAD_MAX)));
            len = $urandom_range(0, 2);
            for (k = 0; k < len; k++) begin
                offer_char(t_byte'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 1) == 1) begin
                offer(t_byte'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, "");
            end
        end else if (kind < 80) begin
            offer_char(($urandom_range(0, 1) == 1) ? t_byte'($urandom_range(8'h80, 8'hc1))
                                                   : t_byte'($urandom_range(8'hf5, 8'hff)));
        end else if (kind < 92) begin
            offer(t_byte'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, 1'b0, "");
        end else begin
            offer(t_byte'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, "");
        end
    endtask

    // Receiver: random stalls, a long hold-off on request, and the check of every
    // transfer against the oldest expected byte.
    always @(posedge i_clk) begin
        t_esc_char want;
        int        g;
        if (out_if.valid && out_if.ready) begin
            chars_checked++;
            if (out_if.string_done) begin
                strings_seen++;
            end
            if (expected_chars.size() == 0) begin
                note_error($sformatf("unexpected output byte %02h last=%0b done=%0b",
                                     out_if.out_byte, out_if.run_last, out_if.string_done));
            end else begin
                want = expected_chars.pop_front();
                if (out_if.out_byte !== want.ch || out_if.run_last !== want.last ||
                    out_if.string_done !== want.done) begin
                    note_error($sformatf(
                        "byte %0d: expected %02h last=%0b done=%0b, got %02h last=%0b done=%0b",
                        chars_checked, want.ch, want.last, want.done,
                        out_if.out_byte, out_if.run_last, out_if.string_done));
                end
            end
        end
        if (!i_rst_n) begin
            out_if.ready  <= 1'b0;
        end else if (hold_asks != hold_served) begin
            hold_served   <= hold_asks;
            hold_left     <= HOLD_CYCLES;
            out_if.ready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            out_if.ready  <= 1'b0;
        end else if (quiet) begin
            out_if.ready  <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            out_if.ready  <= 1'b0;
        end else begin
            g = pick_gap();
            if (g == 0) begin
                out_if.ready <= 1'b1;
            end else begin
                stall_left   <= g - 1;
                out_if.ready <= 1'b0;
            end
        end
    end

    // Watchdog: a run that exceeds the cycle limit ends as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still expected",
                     cycle_count, expected_chars.size());
            $display("json_string_escaper_utf8_tb: done, errors");
            $finish;
        end
    end

    initial begin
        int rand_target;
        int r;
        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.data_byte  <= 8'h00;
        in_if.has_byte   <= 1'b0;
        in_if.string_end <= 1'b0;
        model_open    = 1'b0;
        model_held    = '{default: 8'h00};
        model_held_n  = 0;
        model_seq_len = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: escapes, extremes and each UTF-8 corner in turn.
        for (r = 0; r < DIRECTED_ROWS; r++) begin
            offer(directed[r].data, directed[r].has, directed[r].fin,
                  directed[r].typed_on, directed[r].typed);
        end

        // The sender stops until the block has delivered everything it owes.
        in_if.valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);

        // Random part. Early on the receiver holds off for a long stretch while the
        // sender keeps offering, so the block fills and stalls its input; later a
        // stretch runs with no idling on either side.
        rand_target = items_sent + RANDOM_ITEMS;
        while (items_sent < rand_target) begin
            if (items_sent >= rand_target - RANDOM_ITEMS + 30 && hold_asks == 0) begin
                hold_asks <= 1;
            end
            quiet <= (items_sent >= rand_target - 60 && items_sent < rand_target - 35);
            send_token();
        end
        in_if.valid <= 1'b0;
        quiet       <= 1'b0;

        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_chars.size() != 0) begin
            note_error($sformatf("%0d expected bytes never arrived", expected_chars.size()));
        end

        $display("Sent %0d string transfers (directed corners, then random UTF-8 text).",
                 items_sent);
        $display("Checked %0d output bytes over %0d closed strings, %0d mismatches.",
                 chars_checked, strings_seen, err_count);
        if (err_count == 0) begin
            $display("json_string_escaper_utf8_tb: done, clean");
        end else begin
            $display("json_string_escaper_utf8_tb: done, errors");
        end
        $finish;
    end

endmodule
